/* rtl/lpwe_pkg.sv */
// Package for the LSB pixel watermark embedder.
// Holds the item structs, the register map, the format codes and the generator shifts.
// Used by every module under rtl; depends on nothing else.
package lpwe_pkg;

  // Configuration port geometry: six registers at a stride of eight bytes.
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned RegSelW  = 3;

  // Register indexes.
  localparam logic [RegSelW-1:0] REG_FP_WORD0      = 3'd0;
  localparam logic [RegSelW-1:0] REG_FP_WORD1      = 3'd1;
  localparam logic [RegSelW-1:0] REG_FP_WORD2      = 3'd2;
  localparam logic [RegSelW-1:0] REG_FP_WORD3      = 3'd3;
  localparam logic [RegSelW-1:0] REG_PIXEL_FORMAT  = 3'd4;
  localparam logic [RegSelW-1:0] REG_IDENTITY_VLD  = 3'd5;

  // Pixel format codes; the other codes pass pixels through.
  localparam logic [1:0] FMT_BLUE_BYTE0 = 2'd0;
  localparam logic [1:0] FMT_BLUE_BYTE2 = 2'd1;

  // Fingerprint and generator sizes.
  localparam int unsigned FpW      = 256;
  localparam int unsigned FpIdxW   = 8;
  localparam int unsigned SeedW    = 128;
  localparam int unsigned WordW    = 32;
  localparam int unsigned HitBitsW = 4;

  // Xorshift128 shift amounts.
  localparam int unsigned ShiftA = 11;
  localparam int unsigned ShiftB = 8;
  localparam int unsigned ShiftC = 19;

  // Bit positions of the blue least significant bit.
  localparam int unsigned BlueLsbLo = 0;
  localparam int unsigned BlueLsbHi = 16;

  // One input item.
  typedef struct packed {
    logic [31:0] pixel_in;
    logic        frame_start;
  } pixel_item_t;

  // One result item.
  typedef struct packed {
    logic [31:0] pixel_out;
    logic        bit_embedded;
  } result_item_t;

  // Register contents seen by the datapath.
  typedef struct packed {
    logic [FpW-1:0] fingerprint;
    logic [1:0]     pixel_format;
    logic           identity_valid;
  } cfg_t;

  // Generator control for one item.
  typedef struct packed {
    logic fire;
    logic reseed;
    logic advance;
  } prng_ctl_t;

endpackage

/* rtl/lpwe_regs.sv */
// Configuration registers of the watermark embedder behind an APB-style port.
// Depends on lpwe_pkg for the register map and the cfg_t struct.
module lpwe_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpwe_pkg::CfgAddrW-1:0]  paddr,
  input  logic [lpwe_pkg::CfgDataW-1:0]  pwdata,
  output logic [lpwe_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready,
  output lpwe_pkg::cfg_t                 cfg
);

  logic [63:0]                      fp_word0;
  logic [63:0]                      fp_word1;
  logic [63:0]                      fp_word2;
  logic [63:0]                      fp_word3;
  logic [1:0]                       pixel_format;
  logic                             identity_valid;
  logic                             wr_en;
  logic [lpwe_pkg::RegSelW-1:0]     reg_sel;

  // Registers are addressed by the eight-byte word index.
  assign reg_sel = paddr[lpwe_pkg::CfgAddrW-1:lpwe_pkg::CfgAddrW-lpwe_pkg::RegSelW];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes; indexes beyond the map are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      fp_word0       <= '0;
      fp_word1       <= '0;
      fp_word2       <= '0;
      fp_word3       <= '0;
      pixel_format   <= '0;
      identity_valid <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        lpwe_pkg::REG_FP_WORD0:     fp_word0       <= pwdata;
        lpwe_pkg::REG_FP_WORD1:     fp_word1       <= pwdata;
        lpwe_pkg::REG_FP_WORD2:     fp_word2       <= pwdata;
        lpwe_pkg::REG_FP_WORD3:     fp_word3       <= pwdata;
        lpwe_pkg::REG_PIXEL_FORMAT: pixel_format   <= pwdata[1:0];
        lpwe_pkg::REG_IDENTITY_VLD: identity_valid <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_sel)
      lpwe_pkg::REG_FP_WORD0:     prdata = fp_word0;
      lpwe_pkg::REG_FP_WORD1:     prdata = fp_word1;
      lpwe_pkg::REG_FP_WORD2:     prdata = fp_word2;
      lpwe_pkg::REG_FP_WORD3:     prdata = fp_word3;
      lpwe_pkg::REG_PIXEL_FORMAT: prdata = {62'd0, pixel_format};
      lpwe_pkg::REG_IDENTITY_VLD: prdata = {63'd0, identity_valid};
      default:                    prdata = '0;
    endcase
  end

  assign cfg.fingerprint    = {fp_word3, fp_word2, fp_word1, fp_word0};
  assign cfg.pixel_format   = pixel_format;
  assign cfg.identity_valid = identity_valid;

endmodule

/* rtl/lpwe_prng.sv */
// Xorshift128 placement generator: four state words, reseed and one step per item.
// Depends on lpwe_pkg for word widths, shift amounts and prng_ctl_t.
module lpwe_prng (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lpwe_pkg::SeedW-1:0]   seed,
  input  lpwe_pkg::prng_ctl_t          ctl,
  output logic [lpwe_pkg::WordW-1:0]   rnd
);

  logic [lpwe_pkg::WordW-1:0] words     [4];
  logic [lpwe_pkg::WordW-1:0] cur       [4];
  logic [lpwe_pkg::WordW-1:0] t_a;
  logic [lpwe_pkg::WordW-1:0] t_b;
  logic                       seed_zero;

  // A seed of all zeros would lock the generator, so word 0 is forced to one.
  assign seed_zero = (seed == '0);

  // State the step starts from: the fresh seed at frame start, else the stored words.
  always_comb begin
    if (ctl.reseed) begin
      cur[0] = seed_zero ? lpwe_pkg::WordW'(1) : seed[31:0];
      cur[1] = seed[63:32];
      cur[2] = seed[95:64];
      cur[3] = seed[127:96];
    end else begin
      cur[0] = words[0];
      cur[1] = words[1];
      cur[2] = words[2];
      cur[3] = words[3];
    end
  end

  // One xorshift128 step.
  assign t_a = cur[3] ^ (cur[3] << lpwe_pkg::ShiftA);
  assign t_b = t_a ^ (t_a >> lpwe_pkg::ShiftB);
  assign rnd = t_b ^ cur[0] ^ (cur[0] >> lpwe_pkg::ShiftC);

  // Without a step the state takes the words the step would start from: seed or stored words.
  always_ff @(posedge clk) begin
    if (rst) begin
      words[0] <= '0;
      words[1] <= '0;
      words[2] <= '0;
      words[3] <= '0;
    end else if (ctl.fire) begin
      if (ctl.advance) begin
        words[0] <= rnd;
        words[1] <= cur[0];
        words[2] <= cur[1];
        words[3] <= cur[2];
      end else begin
        words[0] <= cur[0];
        words[1] <= cur[1];
        words[2] <= cur[2];
        words[3] <= cur[3];
      end
    end
  end

endmodule

/* rtl/lsb_pixel_watermark_embed.sv */
// Top level of the LSB pixel watermark embedder.
// Instantiates lpwe_regs and lpwe_prng; uses lpwe_pkg for item and config types.
//
// Usage:
//   Pixels enter on the pixel channel (valid/ready, struct pixel_item_t) in
//   row-major order; frame_start on the first pixel of a frame reseeds the
//   generator from fingerprint bits 0..127 and restarts the bit index.
//   Each item yields exactly one result on the result channel (valid/ready,
//   struct result_item_t): the pixel, with its blue LSB possibly replaced by
//   the next fingerprint bit, and a flag that says so.
//   The path holds an input register, then one pass of generator and
//   embed logic into the result register. Throughput is one item per clock
//   while the receiver does not stall; it is bounded by the single generator
//   step that each item needs. When the receiver stalls, the result register
//   holds, then the input register fills, and only then does pixel_ready drop.
//   Configuration is written over the APB-style port at byte address 8*i;
//   the user must do so only while no item is in flight, which the block
//   does not enforce. pready is always high. Synchronous reset clears all
//   registers, the generator state and bit index, and empties both pipeline registers.
module lsb_pixel_watermark_embed (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pixel_valid,
  output logic                           pixel_ready,
  input  lpwe_pkg::pixel_item_t          pixel,
  output logic                           result_valid,
  input  logic                           result_ready,
  output lpwe_pkg::result_item_t         result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpwe_pkg::CfgAddrW-1:0]  paddr,
  input  logic [lpwe_pkg::CfgDataW-1:0]  pwdata,
  output logic [lpwe_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);

  lpwe_pkg::cfg_t                  cfg;
  lpwe_pkg::prng_ctl_t             prng_ctl;
  lpwe_pkg::pixel_item_t           s1_item;
  logic                            s1_valid;
  logic                            s1_go;
  logic [lpwe_pkg::WordW-1:0]      rnd;
  logic [lpwe_pkg::FpIdxW-1:0]     bit_index;
  logic [lpwe_pkg::FpIdxW-1:0]     idx_cur;
  logic [lpwe_pkg::FpIdxW-1:0]     bit_index_next;
  logic                            enabled;
  logic                            hit;
  logic                            fp_bit;
  logic [31:0]                     pixel_mod;
  lpwe_pkg::result_item_t          result_next;

  lpwe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline control: the input register moves on when the result register is free.
  assign s1_go       = s1_valid && (!result_valid || result_ready);
  assign pixel_ready = !s1_valid || s1_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_ready && pixel_valid) begin
      s1_item <= pixel;
    end
  end

  // Embedding is active only with an identity set and a supported format.
  assign enabled = cfg.identity_valid &&
                   (cfg.pixel_format == lpwe_pkg::FMT_BLUE_BYTE0 ||
                    cfg.pixel_format == lpwe_pkg::FMT_BLUE_BYTE2);

  assign prng_ctl.fire    = s1_go;
  assign prng_ctl.reseed  = s1_item.frame_start;
  assign prng_ctl.advance = enabled;

  lpwe_prng u_prng (
    .clk  (clk),
    .rst  (rst),
    .seed (cfg.fingerprint[lpwe_pkg::SeedW-1:0]),
    .ctl  (prng_ctl),
    .rnd  (rnd)
  );

  // A pixel takes a bit when the new generator output has its low nibble clear.
  assign idx_cur = s1_item.frame_start ? '0 : bit_index;
  assign hit     = enabled && (rnd[lpwe_pkg::HitBitsW-1:0] == '0);
  assign fp_bit  = cfg.fingerprint[idx_cur];
  assign bit_index_next = hit ? idx_cur + lpwe_pkg::FpIdxW'(1) : idx_cur;

  // Replace the blue LSB in byte 0 or byte 2.
  always_comb begin
    pixel_mod = s1_item.pixel_in;
    if (cfg.pixel_format == lpwe_pkg::FMT_BLUE_BYTE0) begin
      pixel_mod[lpwe_pkg::BlueLsbLo] = fp_bit;
    end else begin
      pixel_mod[lpwe_pkg::BlueLsbHi] = fp_bit;
    end
  end

  assign result_next.pixel_out    = hit ? pixel_mod : s1_item.pixel_in;
  assign result_next.bit_embedded = hit;

  // Fingerprint bit index.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_index <= '0;
    end else if (s1_go) begin
      bit_index <= bit_index_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      result <= result_next;
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Testbench for lsb_pixel_watermark_embed: directed and random pixel streams with register
// writes between phases, each result checked against an embedder model kept in this file.
// Depends on lpwe_pkg and the RTL top level; reads no files.
module tb;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned ShortItems   = 900;
  localparam int unsigned LongFrameLen = 400;
  localparam int unsigned WrapRunLen   = 300;
  localparam int unsigned HoldCycles   = 64;

  // Register slots past the end of the map, and the two pass-through format codes.
  localparam logic [lpwe_pkg::RegSelW-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [lpwe_pkg::RegSelW-1:0] REG_UNUSED_HI = 3'd7;
  localparam logic [1:0]                   FMT_PASS_2    = 2'd2;
  localparam logic [1:0]                   FMT_PASS_3    = 2'd3;

  // One row of the directed stimulus: either a register write or a pixel.
  typedef struct packed {
    logic                          is_cfg;
    logic [lpwe_pkg::RegSelW-1:0]  sel;
    logic [63:0]                   value;
    lpwe_pkg::pixel_item_t         item;
    logic                          typed;
    lpwe_pkg::result_item_t        want;
  } plan_row_t;

  logic                          clk;
  logic                          rst;
  logic                          pixel_valid;
  logic                          pixel_ready;
  lpwe_pkg::pixel_item_t         pixel;
  logic                          result_valid;
  logic                          result_ready;
  lpwe_pkg::result_item_t        result;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lpwe_pkg::CfgAddrW-1:0] paddr;
  logic [lpwe_pkg::CfgDataW-1:0] pwdata;
  logic [lpwe_pkg::CfgDataW-1:0] prdata;
  logic                          pready;

  // Shadow registers and the embedder state that the model keeps.
  logic [63:0] fp_words [4];
  logic [1:0]  fmt_reg;
  logic        idv_reg;
  logic [31:0] gen_words [4];
  logic [7:0]  bit_idx;

  lpwe_pkg::result_item_t pixel_expect_q [$];
  plan_row_t              plan [$];
  int unsigned            fails;
  int unsigned            results_seen;
  int unsigned            cycles;
  bit                     calm;

  lsb_pixel_watermark_embed uut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Model of one pixel: optional reseed, a generator step while enabled, and the LSB replacement.
  function automatic lpwe_pkg::result_item_t embed_pixel(input lpwe_pkg::pixel_item_t it);
    lpwe_pkg::result_item_t r;
    logic [31:0]  t;
    logic [31:0]  w0;
    logic [255:0] fp_bits;
    int unsigned  pos;
    r.pixel_out    = it.pixel_in;
    r.bit_embedded = 1'b0;
    if (it.frame_start) begin
      gen_words[0] = fp_words[0][31:0];
      gen_words[1] = fp_words[0][63:32];
      gen_words[2] = fp_words[1][31:0];
      gen_words[3] = fp_words[1][63:32];
      // An all-zero seed would lock the generator at zero.
      if ({fp_words[1], fp_words[0]} == '0) gen_words[0] = 32'd1;
      bit_idx = '0;
    end
    if (idv_reg && (fmt_reg == lpwe_pkg::FMT_BLUE_BYTE0 ||
                    fmt_reg == lpwe_pkg::FMT_BLUE_BYTE2)) begin
      t  = gen_words[3];
      w0 = gen_words[0];
      t  = t ^ (t << lpwe_pkg::ShiftA);
      t  = t ^ (t >> lpwe_pkg::ShiftB);
      gen_words[3] = gen_words[2];
      gen_words[2] = gen_words[1];
      gen_words[1] = w0;
      t  = t ^ w0 ^ (w0 >> lpwe_pkg::ShiftC);
      gen_words[0] = t;
      if (t[lpwe_pkg::HitBitsW-1:0] == '0) begin
        fp_bits = {fp_words[3], fp_words[2], fp_words[1], fp_words[0]};
        pos = (fmt_reg == lpwe_pkg::FMT_BLUE_BYTE0) ? lpwe_pkg::BlueLsbLo
                                                     : lpwe_pkg::BlueLsbHi;
        r.pixel_out[pos] = fp_bits[bit_idx];
        r.bit_embedded   = 1'b1;
        bit_idx = bit_idx + 8'd1;
      end
    end
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [lpwe_pkg::RegSelW-1:0] sel,
                                        input logic [63:0] value);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.sel    = sel;
    r.value  = value;
    return r;
  endfunction

  function automatic plan_row_t pix_row(input logic [31:0] pix, input logic start);
    plan_row_t r;
    r                  = '0;
    r.item.pixel_in    = pix;
    r.item.frame_start = start;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [31:0] pix, input logic start,
                                          input logic [31:0] pout, input logic emb);
    plan_row_t r;
    r                   = pix_row(pix, start);
    r.typed             = 1'b1;
    r.want.pixel_out    = pout;
    r.want.bit_embedded = emb;
    return r;
  endfunction

  function automatic logic [31:0] pick_pixel();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offer one pixel, hold it until accepted, then queue what the block should return.
  task automatic offer_pixel(input lpwe_pkg::pixel_item_t it, input logic typed,
                             input lpwe_pkg::result_item_t want);
    lpwe_pkg::result_item_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 16) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= it;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    predicted = embed_pixel(it);
    pixel_expect_q.push_back(typed ? want : predicted);
  endtask

  // Stop offering and wait until every queued result has come back.
  task automatic settle();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk);
  endtask

  // Write one register, then read it back and compare with the shadow copy.
  task automatic program_reg(input logic [lpwe_pkg::RegSelW-1:0] sel,
                             input logic [63:0] value);
    logic [63:0] held;
    logic [63:0] readback;
    bit          mapped;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    mapped = 1'b1;
    held   = '0;
    case (sel)
      lpwe_pkg::REG_FP_WORD0, lpwe_pkg::REG_FP_WORD1,
      lpwe_pkg::REG_FP_WORD2, lpwe_pkg::REG_FP_WORD3: begin
        fp_words[sel[1:0]] = value;
        held = value;
      end
      lpwe_pkg::REG_PIXEL_FORMAT: begin
        fmt_reg = value[1:0];
        held    = {62'b0, fmt_reg};
      end
      lpwe_pkg::REG_IDENTITY_VLD: begin
        idv_reg = value[0];
        held    = {63'b0, idv_reg};
      end
      default: mapped = 1'b0;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (mapped && readback !== held) begin
      $error("register %0d readback: expected %h, got %h", sel, held, readback);
      fails++;
    end
  endtask

  // New settings for a phase; a zero seed phase clears the low fingerprint words.
  task automatic shuffle_settings(input bit all_regs, input bit zero_seed);
    logic [63:0] word;
    logic [1:0]  fmt;
    for (int w = 0; w < 4; w++) begin
      if (all_regs || (zero_seed && w < 2) || $urandom_range(2) != 0) begin
        case ($urandom_range(7))
          0:       word = '0;
          1:       word = '1;
          default: word = {$urandom, $urandom};
        endcase
        if (zero_seed && w < 2) word = '0;
        program_reg(lpwe_pkg::REG_FP_WORD0 + lpwe_pkg::RegSelW'(w), word);
      end
    end
    if (all_regs || $urandom_range(2) != 0) begin
      case ($urandom_range(9))
        0:          fmt = FMT_PASS_2;
        1:          fmt = FMT_PASS_3;
        2, 3, 4, 5: fmt = lpwe_pkg::FMT_BLUE_BYTE2;
        default:    fmt = lpwe_pkg::FMT_BLUE_BYTE0;
      endcase
      program_reg(lpwe_pkg::REG_PIXEL_FORMAT, {62'b0, fmt});
    end
    if (all_regs || $urandom_range(2) != 0)
      program_reg(lpwe_pkg::REG_IDENTITY_VLD, {63'b0, ($urandom_range(7) != 0)});
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      lpwe_pkg::result_item_t want;
      results_seen++;
      if (pixel_expect_q.size() == 0) begin
        $error("result with no pixel pending: pixel_out=%h bit_embedded=%b",
               result.pixel_out, result.bit_embedded);
        fails++;
      end else begin
        want = pixel_expect_q.pop_front();
        if (result.pixel_out !== want.pixel_out) begin
          $error("pixel_out: expected %h, got %h", want.pixel_out, result.pixel_out);
          fails++;
        end
        if (result.bit_embedded !== want.bit_embedded) begin
          $error("bit_embedded: expected %b, got %b", want.bit_embedded, result.bit_embedded);
          fails++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls, plus two long hold-offs that back the block up.
  initial begin : receiver
    int unsigned hold_left;
    bit          held_once;
    bit          held_twice;
    result_ready = 1'b0;
    hold_left    = 0;
    held_once    = 1'b0;
    held_twice   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && !held_once && results_seen >= 400) begin
        hold_left = HoldCycles;
        held_once = 1'b1;
      end else if (hold_left == 0 && !held_twice && results_seen >= 1200) begin
        hold_left  = HoldCycles;
        held_twice = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin
    plan_row_t             row;
    lpwe_pkg::pixel_item_t it;
    int unsigned           sent;
    int unsigned           len;
    int unsigned           phase;
    rst         = 1'b1;
    pixel_valid = 1'b0;
    pixel       = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    calm        = 1'b0;
    fails       = 0;
    results_seen = 0;
    cycles      = 0;
    for (int i = 0; i < 4; i++) begin
      fp_words[i]  = '0;
      gen_words[i] = '0;
    end
    fmt_reg = '0;
    idv_reg = 1'b0;
    bit_idx = '0;

    // Out of reset the identity is unset, so pixels pass untouched.
    plan.push_back(known_row(32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0));
    plan.push_back(known_row(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0));
    // With no frame start yet the generator stays at zero and every pixel takes a bit.
    plan.push_back(cfg_row(lpwe_pkg::REG_FP_WORD0, '1));
    plan.push_back(cfg_row(lpwe_pkg::REG_IDENTITY_VLD, 64'd1));
    plan.push_back(known_row(32'h0000_0000, 1'b0, 32'h0000_0001, 1'b1));
    plan.push_back(known_row(32'hFFFF_FFFE, 1'b0, 32'hFFFF_FFFF, 1'b1));
    plan.push_back(cfg_row(lpwe_pkg::REG_PIXEL_FORMAT, {62'b0, lpwe_pkg::FMT_BLUE_BYTE2}));
    plan.push_back(known_row(32'h0000_0000, 1'b0, 32'h0001_0000, 1'b1));
    plan.push_back(known_row(32'hFFFE_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1));
    // A long run on the zero generator walks the bit index through all four words
    // and past its wrap, ending inside word 0.
    plan.push_back(cfg_row(lpwe_pkg::REG_FP_WORD2, 64'h0F0F_0F0F_3C3C_3C3C));
    plan.push_back(cfg_row(lpwe_pkg::REG_FP_WORD3, 64'h9669_9669_A55A_A55A));
    for (int n = 0; n < WrapRunLen; n++) plan.push_back(pix_row(pick_pixel(), 1'b0));
    // Fingerprint bits are read live, so a cleared word embeds zeros at once.
    plan.push_back(cfg_row(lpwe_pkg::REG_FP_WORD0, '0));
    plan.push_back(known_row(32'hFFFF_FFFF, 1'b0, 32'hFFFE_FFFF, 1'b1));
    // Unsupported formats pass through; a frame start here reseeds from an all-zero seed.
    plan.push_back(cfg_row(lpwe_pkg::REG_PIXEL_FORMAT, {62'b0, FMT_PASS_2}));
    plan.push_back(known_row(32'h1234_5678, 1'b0, 32'h1234_5678, 1'b0));
    plan.push_back(known_row(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0));
    plan.push_back(cfg_row(lpwe_pkg::REG_PIXEL_FORMAT, {62'b0, FMT_PASS_3}));
    plan.push_back(known_row(32'h8765_4321, 1'b0, 32'h8765_4321, 1'b0));
    plan.push_back(cfg_row(lpwe_pkg::REG_PIXEL_FORMAT, {62'b0, lpwe_pkg::FMT_BLUE_BYTE0}));
    plan.push_back(pix_row(32'h0000_0000, 1'b0));
    plan.push_back(pix_row(32'hFFFF_FFFF, 1'b0));
    plan.push_back(pix_row(32'h5A5A_5A5A, 1'b0));
    // Writes past the register map must change nothing.
    plan.push_back(cfg_row(REG_UNUSED_LO, '1));
    plan.push_back(cfg_row(REG_UNUSED_HI, '1));
    plan.push_back(cfg_row(lpwe_pkg::REG_FP_WORD0, 64'h0123_4567_89AB_CDEF));
    plan.push_back(cfg_row(lpwe_pkg::REG_FP_WORD1, 64'hFEDC_BA98_7654_3210));
    plan.push_back(cfg_row(lpwe_pkg::REG_FP_WORD2, '1));
    plan.push_back(cfg_row(lpwe_pkg::REG_FP_WORD3, 64'h8000_0000_0000_0001));
    plan.push_back(pix_row(32'h00FF_00FF, 1'b1));
    plan.push_back(pix_row(32'hFFFF_FFFF, 1'b0));
    plan.push_back(pix_row(32'h0000_0000, 1'b0));
    plan.push_back(pix_row(32'hA5A5_A5A5, 1'b0));
    plan.push_back(pix_row(32'h0101_0101, 1'b0));
    plan.push_back(pix_row(32'hFEFE_FEFE, 1'b1));
    plan.push_back(pix_row(32'h7FFF_FFFF, 1'b0));
    // Clearing the identity passes pixels through, even on a frame start.
    plan.push_back(cfg_row(lpwe_pkg::REG_IDENTITY_VLD, 64'd0));
    plan.push_back(known_row(32'hC3C3_C3C3, 1'b1, 32'hC3C3_C3C3, 1'b0));
    plan.push_back(known_row(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0));
    plan.push_back(cfg_row(lpwe_pkg::REG_IDENTITY_VLD, 64'd1));
    plan.push_back(pix_row(32'h0000_0000, 1'b0));
    plan.push_back(pix_row(32'hFFFF_FFFF, 1'b1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        settle();
        program_reg(row.sel, row.value);
      end else begin
        offer_pixel(row.item, row.typed, row.want);
      end
    end

    // Short frames under changing settings; most start with a frame start.
    sent  = 0;
    phase = 0;
    while (sent < ShortItems) begin
      settle();
      shuffle_settings(phase == 0, phase == 3);
      len = $urandom_range(60, 200);
      for (int k = 0; k < len; k++) begin
        it.pixel_in    = pick_pixel();
        it.frame_start = (k == 0) ? ($urandom_range(7) != 0) : ($urandom_range(99) == 0);
        offer_pixel(it, 1'b0, '0);
      end
      sent += len;
      phase++;
    end

    // One frame at full rate with no idling on either side.
    settle();
    shuffle_settings(1'b1, 1'b0);
    program_reg(lpwe_pkg::REG_PIXEL_FORMAT,
                {62'b0, ($urandom_range(1) != 0) ? lpwe_pkg::FMT_BLUE_BYTE2
                                                 : lpwe_pkg::FMT_BLUE_BYTE0});
    program_reg(lpwe_pkg::REG_IDENTITY_VLD, 64'd1);
    calm = 1'b1;
    for (int k = 0; k < LongFrameLen; k++) begin
      it.pixel_in    = pick_pixel();
      it.frame_start = (k == 0);
      offer_pixel(it, 1'b0, '0);
    end

    settle();
    calm = 1'b0;
    repeat (8) @(posedge clk);
    if (fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
